// ===== rtl/gmf_pkg.sv =====
`timescale 1ns / 1ps
package gmf_pkg;

  localparam int MAX_COMPONENTS_DEF = 8;
  localparam int MAX_SAMPLES        = 1024;
  localparam int FRAC_BITS          = 16;
  localparam int IDX_W              = 10;
  localparam int POS_W              = IDX_W + FRAC_BITS;

  // divider geometry: numerator is fed MSB first, left aligned
  localparam int NUM_W = 54;
  localparam int QUO_W = 33;
  localparam int NBT_W = 6;

  localparam int EXP_TERMS = 8;
  localparam logic [28:0] E_NEG1_Q30 = 29'd395007542;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef struct packed {
    logic signed [31:0] amplitude;
    logic signed [31:0] center;
    logic signed [31:0] spread;
  } entry_t;

  typedef struct packed {
    logic [2:0]         component;
    logic signed [31:0] grad_amplitude;
    logic signed [31:0] grad_center;
    logic signed [31:0] grad_spread;
    logic [30:0]        residual;
    logic               zero_width;
    logic               last;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD,
    S_SETUP,
    S_DIV_R,
    S_DIV_R_W,
    S_MUL_U,
    S_EXP_INIT,
    S_EXP_MUL,
    S_EXP_DIV,
    S_EXP_DIV_W,
    S_EXP_POW,
    S_EXP_POW_W,
    S_EXP_FIN,
    S_MUL_M,
    S_MUL_T1,
    S_MUL_T2,
    S_DIV_GB,
    S_DIV_GB_W,
    S_DIV_GS,
    S_DIV_GS_W,
    S_EMIT
  } state_t;

  // signed saturation of a magnitude with a sticky overflow bit
  function automatic logic signed [31:0] sat32(input logic neg, input logic [QUO_W-1:0] mag,
                                               input logic ovf);
    logic signed [31:0] res;
    if (neg) begin
      if (ovf || mag > 33'h0_8000_0000) res = 32'sh8000_0000;
      else res = -$signed(mag[31:0]);
    end else begin
      if (ovf || mag > 33'h0_7FFF_FFFF) res = 32'sh7FFF_FFFF;
      else res = $signed(mag[31:0]);
    end
    return res;
  endfunction

endpackage

// ===== rtl/gmf_if.sv =====
`timescale 1ns / 1ps
interface gmf_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [2:0]         slot;
  logic signed [31:0] amplitude;
  logic signed [31:0] center;
  logic signed [31:0] spread;
  logic [9:0]         sample_index;
  logic signed [31:0] sample_value;

  modport source (output valid, command, slot, amplitude, center, spread, sample_index,
                  sample_value, input ready);
  modport sink (input valid, command, slot, amplitude, center, spread, sample_index,
                sample_value, output ready);
endinterface

interface gmf_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         component;
  logic signed [31:0] grad_amplitude;
  logic signed [31:0] grad_center;
  logic signed [31:0] grad_spread;
  logic [30:0]        residual;
  logic               zero_width;
  logic               last;

  modport source (output valid, component, grad_amplitude, grad_center, grad_spread,
                  residual, zero_width, last, input ready);
  modport sink (input valid, component, grad_amplitude, grad_center, grad_spread,
                residual, zero_width, last, output ready);
endinterface

// ===== rtl/gmf_table.sv =====
`timescale 1ns / 1ps
module gmf_table #(
  parameter int DEPTH = gmf_pkg::MAX_COMPONENTS_DEF,
  parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  logic [IW-1:0]   wr_addr,
  input  gmf_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  logic [IW-1:0]   rd_addr,
  output gmf_pkg::entry_t rd_data
);
  import gmf_pkg::*;

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  entry_t           rd_r;
  logic             rd_vld_r;

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) vld_r[wr_addr] <= 1'b1;
      if (rd_en) rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_r <= mem[rd_addr];
  end

  assign rd_data = rd_vld_r ? rd_r : '0;

endmodule

// ===== rtl/gmf_div.sv =====
`timescale 1ns / 1ps
module gmf_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [gmf_pkg::NUM_W-1:0]     num,
  input  logic [31:0]                   den,
  input  logic [gmf_pkg::NBT_W-1:0]     nbits,
  output logic                          busy,
  output logic [gmf_pkg::QUO_W-1:0]     quo,
  output logic                          ovf
);
  import gmf_pkg::*;

  logic [NUM_W-1:0] num_r;
  logic [31:0]      den_r;
  logic [31:0]      rem_r;
  logic [QUO_W-1:0] quo_r;
  logic             ovf_r;
  logic [NBT_W-1:0] cnt_r;
  logic             busy_r;
  logic [32:0]      sh;
  logic             ge;

  // one quotient bit per cycle, restoring
  assign sh = {rem_r, num_r[NUM_W-1]};
  assign ge = sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= nbits;
    end else if (busy_r) begin
      cnt_r <= cnt_r - NBT_W'(1);
      if (cnt_r == NBT_W'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      rem_r <= ge ? 32'(sh - {1'b0, den_r}) : sh[31:0];
      quo_r <= {quo_r[QUO_W-2:0], ge};
      ovf_r <= ovf_r | quo_r[QUO_W-1];
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;
  assign ovf  = ovf_r;

endmodule

// ===== rtl/gmf_core.sv =====
`timescale 1ns / 1ps
module gmf_core #(
  parameter int MAX_COMPONENTS = gmf_pkg::MAX_COMPONENTS_DEF,
  parameter int IW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1,
  parameter int CW = $clog2(MAX_COMPONENTS + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [CW-1:0]              count,
  input  logic [gmf_pkg::IDX_W-1:0]  idx,
  input  logic signed [31:0]         value,
  output logic                       idle,
  output logic                       rd_en,
  output logic [IW-1:0]              rd_addr,
  input  gmf_pkg::entry_t            rd_data,
  output logic                       res_valid,
  output gmf_pkg::res_t              res,
  input  logic                       res_take
);
  import gmf_pkg::*;

  localparam int SUMW = 34 + $clog2(MAX_COMPONENTS + 1);
  localparam int DW   = SUMW + 1;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]   idx_r;
  logic signed [31:0] v_r;
  logic [CW-1:0]      count_r;
  logic [IW-1:0]      j_r;
  logic signed [SUMW-1:0] sum_r;

  logic [32:0] dmag_r;
  logic [31:0] smag_r, amag_r;
  logic        aneg_r, gb_neg_r, gs_neg_r, zw_r;
  logic [18:0] r_r;
  logic [4:0]  n_r;
  logic [3:0]  k_r;
  logic [29:0] f30_r;
  logic [30:0] t_r;
  logic [16:0] g_r;
  logic [31:0] m_r;
  logic [33:0] t1_r;
  logic [36:0] t2_r;
  logic signed [31:0] gb_r, gs_r;
  logic [64:0] prod_r;

  logic [33:0] mul_a;
  logic [30:0] mul_b;

  logic             div_start, div_busy, div_ovf;
  logic [NUM_W-1:0] div_num;
  logic [31:0]      div_den;
  logic [NBT_W-1:0] div_nbits;
  logic [QUO_W-1:0] div_quo;

  // component geometry from the table word
  logic [POS_W-1:0]   pos;
  logic signed [33:0] d_s;
  logic [32:0]        dmag;
  logic [31:0]        smag, amag;
  logic               far, zw;

  logic [64:0] p_rnd, m_rnd;
  logic [31:0] m_c;
  logic [33:0] t1_c;
  logic        last_c;
  logic signed [DW-1:0] diff;
  logic [DW-1:0]        dabs;

  logic [31:0] recip_k;
  logic [30:0] quo_k;

  gmf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .nbits (div_nbits),
    .busy  (div_busy),
    .quo   (div_quo),
    .ovf   (div_ovf)
  );

  assign pos  = {idx_r, {FRAC_BITS{1'b0}}};
  assign d_s  = $signed({{(34 - POS_W){1'b0}}, pos}) - 34'(rd_data.center);
  assign dmag = d_s[33] ? 33'(-d_s) : 33'(d_s);
  assign smag = rd_data.spread[31] ? 32'(-rd_data.spread) : 32'(rd_data.spread);
  assign amag = rd_data.amplitude[31] ? 32'(-rd_data.amplitude) : 32'(rd_data.amplitude);
  assign far  = {2'b00, dmag} >= {smag, 3'b000};
  assign zw   = rd_data.spread == 32'sd0;

  assign p_rnd  = prod_r + 65'(1) * (65'(1) << 29);
  assign m_rnd  = prod_r + (65'(1) << 15);
  assign m_c    = m_rnd[47:16];
  assign t1_c   = prod_r[49:16];
  assign last_c = (CW'(j_r) + CW'(1)) == count_r;

  assign diff = DW'(sum_r) - DW'(v_r);
  assign dabs = diff[DW-1] ? DW'(-diff) : DW'(diff);

  // series divisor k as a reciprocal multiply, exact for dividends below 2^31
  always_comb begin
    recip_k = 32'h8000_0000;
    quo_k   = prod_r[64:34];
    case (k_r)
      4'd1: quo_k = prod_r[61:31];
      4'd2: quo_k = prod_r[62:32];
      4'd3: begin
        recip_k = 32'hAAAA_AAAB;
        quo_k   = prod_r[63:33];
      end
      4'd4: quo_k = prod_r[63:33];
      4'd5: recip_k = 32'hCCCC_CCCD;
      4'd6: recip_k = 32'hAAAA_AAAB;
      4'd7: recip_k = 32'h9249_2493;
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:      if (start) state_nxt = S_RD;
      S_RD:        state_nxt = S_SETUP;
      S_SETUP:     state_nxt = (zw || far) ? S_EMIT : S_DIV_R;
      S_DIV_R:     state_nxt = S_DIV_R_W;
      S_DIV_R_W:   if (!div_busy) state_nxt = S_MUL_U;
      S_MUL_U:     state_nxt = S_EXP_INIT;
      S_EXP_INIT:  state_nxt = S_EXP_MUL;
      S_EXP_MUL:   state_nxt = S_EXP_DIV;
      S_EXP_DIV:   state_nxt = S_EXP_DIV_W;
      S_EXP_DIV_W: state_nxt = (k_r == 4'd1) ? S_EXP_POW : S_EXP_MUL;
      S_EXP_POW:   state_nxt = (n_r == 5'd0) ? S_EXP_FIN : S_EXP_POW_W;
      S_EXP_POW_W: state_nxt = S_EXP_POW;
      S_EXP_FIN:   state_nxt = S_MUL_M;
      S_MUL_M:     state_nxt = S_MUL_T1;
      S_MUL_T1:    state_nxt = S_MUL_T2;
      S_MUL_T2:    state_nxt = S_DIV_GB;
      S_DIV_GB:    state_nxt = S_DIV_GB_W;
      S_DIV_GB_W:  if (!div_busy) state_nxt = S_DIV_GS;
      S_DIV_GS:    state_nxt = S_DIV_GS_W;
      S_DIV_GS_W:  if (!div_busy) state_nxt = S_EMIT;
      S_EMIT:      if (res_take) state_nxt = last_c ? S_IDLE : S_RD;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // per-state unit controls
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_nbits = '0;
    rd_en     = 1'b0;
    res_valid = 1'b0;
    idle      = 1'b0;
    case (state_r)
      S_IDLE: idle = 1'b1;
      S_RD:   rd_en = 1'b1;
      S_DIV_R: begin
        div_start = 1'b1;
        div_num   = {dmag_r, {FRAC_BITS{1'b0}}, 5'b0};
        div_den   = smag_r;
        div_nbits = NBT_W'(49);
      end
      S_MUL_U: begin
        mul_a = 34'(r_r);
        mul_b = 31'(r_r);
      end
      S_EXP_MUL: begin
        mul_a = 34'(f30_r);
        mul_b = t_r;
      end
      S_EXP_DIV: begin
        mul_a = 34'(recip_k);
        mul_b = p_rnd[60:30];
      end
      S_EXP_POW: begin
        mul_a = 34'(t_r);
        mul_b = 31'(E_NEG1_Q30);
      end
      S_MUL_M: begin
        mul_a = 34'(amag_r);
        mul_b = 31'(g_r);
      end
      S_MUL_T1: begin
        mul_a = 34'(m_c);
        mul_b = 31'(r_r);
      end
      S_MUL_T2: begin
        mul_a = t1_c;
        mul_b = 31'(r_r);
      end
      S_DIV_GB: begin
        div_start = 1'b1;
        div_num   = {t1_r, {FRAC_BITS{1'b0}}, 4'b0};
        div_den   = smag_r;
        div_nbits = NBT_W'(50);
      end
      S_DIV_GS: begin
        div_start = 1'b1;
        div_num   = {t2_r, {FRAC_BITS{1'b0}}, 1'b0};
        div_den   = smag_r;
        div_nbits = NBT_W'(53);
      end
      S_EMIT: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r <= '0;
    end else if (state_r == S_IDLE && start) begin
      j_r <= '0;
    end else if (state_r == S_EMIT && res_take && !last_c) begin
      j_r <= j_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 65'(mul_a) * 65'(mul_b);
    case (state_r)
      S_IDLE: begin
        idx_r   <= idx;
        v_r     <= value;
        count_r <= count;
        sum_r   <= '0;
      end
      S_SETUP: begin
        dmag_r   <= dmag;
        smag_r   <= smag;
        amag_r   <= amag;
        aneg_r   <= rd_data.amplitude[31];
        gb_neg_r <= rd_data.amplitude[31] ^ d_s[33];
        gs_neg_r <= rd_data.amplitude[31] ^ rd_data.spread[31];
        zw_r     <= zw;
        g_r      <= '0;
        gb_r     <= '0;
        gs_r     <= '0;
      end
      S_DIV_R_W: if (!div_busy) r_r <= div_quo[18:0];
      S_EXP_INIT: begin
        n_r   <= prod_r[37:33];
        f30_r <= {prod_r[32:17], 14'b0};
        t_r   <= ONE_Q30;
        k_r   <= 4'(EXP_TERMS);
      end
      S_EXP_DIV_W: begin
        t_r <= ONE_Q30 - quo_k;
        k_r <= k_r - 4'd1;
      end
      S_EXP_POW_W: begin
        t_r <= p_rnd[60:30];
        n_r <= n_r - 5'd1;
      end
      S_EXP_FIN: g_r <= 17'((32'(t_r) + 32'h2000) >> 14);
      S_MUL_T1:  m_r <= m_c;
      S_MUL_T2:  t1_r <= t1_c;
      S_DIV_GB: t2_r <= prod_r[52:16];
      S_DIV_GB_W: if (!div_busy) gb_r <= sat32(gb_neg_r, div_quo, div_ovf);
      S_DIV_GS_W: if (!div_busy) begin
        gs_r  <= sat32(gs_neg_r, div_quo, div_ovf);
        sum_r <= aneg_r ? sum_r - SUMW'(m_r) : sum_r + SUMW'(m_r);
      end
      default: ;
    endcase
  end

  assign rd_addr = j_r;

  always_comb begin
    res.component      = 3'(j_r);
    res.grad_amplitude = $signed(32'(g_r));
    res.grad_center    = gb_r;
    res.grad_spread    = gs_r;
    res.zero_width     = zw_r;
    res.last           = last_c;
    res.residual       = '0;
    if (last_c) res.residual = (|dabs[DW-1:31]) ? '1 : dabs[30:0];
  end

endmodule

// ===== rtl/gaussian_mixture_fit_eval_top.sv =====
`timescale 1ns / 1ps
// Gaussian mixture Jacobian and residual unit.
// in_ch takes items: a load (command 0) writes amplitude/center/spread into
// table entry slot and returns nothing; loads to a slot beyond
// the table are dropped. An evaluate (command 1) walks the active components
// in order and sends one item per component on out_ch, carrying the three
// partial derivatives; the final item has last set and the absolute
// residual |model - sample_value|, saturated.
// cfg_we/cfg_data set the active component count (0 reads as 1, values above
// the table depth clip to it). Write it only while the block is idle.
// The work for each component grows with n, the integer part of the
// exponent argument (0..31); a zero width or far tail component skips it.
// The work runs on the shared restoring divider (one quotient bit per cycle,
// three divisions per component not skipped) and the shared 34x31 multiplier.
// Items are handled one at a time; in_ch.ready is high only between items.
// Results pass through one output register: when out_ch stalls the engine
// holds its result and waits, nothing is lost.
// Reset clears the component table (entries read as zero until loaded), sets
// the active count to 1 and empties the output register.
module gaussian_mixture_fit_eval_top #(
  parameter int MAX_COMPONENTS = gmf_pkg::MAX_COMPONENTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  gmf_in_if.sink      in_ch,
  gmf_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_data
);
  import gmf_pkg::*;

  localparam int IW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int CW = $clog2(MAX_COMPONENTS + 1);

  logic [3:0]   cfg_r;
  logic [CW-1:0] count;
  logic         acc;
  logic         core_idle, core_start;
  logic         tbl_we, rd_en;
  logic [IW-1:0] rd_addr;
  entry_t       wr_data, rd_data;
  res_t         core_res, out_r;
  logic         res_valid, res_take;
  logic         out_vld_r, out_vld_nxt;
  logic [IDX_W-1:0] idx;

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= 4'd1;
    else if (cfg_we) cfg_r <= cfg_data;
  end

  // clip the active count into 1..MAX_COMPONENTS
  always_comb begin
    if (cfg_r == 4'd0) count = CW'(1);
    else if ({1'b0, cfg_r} > 5'(MAX_COMPONENTS)) count = CW'(MAX_COMPONENTS);
    else count = CW'(cfg_r);
  end

  // fold the sample index into the waveform length
  assign idx = (MAX_SAMPLES >= (1 << IDX_W)) ? in_ch.sample_index
                                             : (in_ch.sample_index & IDX_W'(MAX_SAMPLES - 1));

  assign in_ch.ready = core_idle;
  assign acc         = in_ch.valid && in_ch.ready;
  assign core_start  = acc && (in_ch.command == CMD_EVAL);
  assign tbl_we      = acc && (in_ch.command == CMD_LOAD) &&
                       ({1'b0, in_ch.slot} < 5'(MAX_COMPONENTS));

  always_comb begin
    wr_data.amplitude = in_ch.amplitude;
    wr_data.center    = in_ch.center;
    wr_data.spread    = in_ch.spread;
  end

  gmf_table #(.DEPTH(MAX_COMPONENTS), .IW(IW)) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tbl_we),
    .wr_addr (IW'(in_ch.slot)),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  gmf_core #(.MAX_COMPONENTS(MAX_COMPONENTS), .IW(IW), .CW(CW)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (core_start),
    .count     (count),
    .idx       (idx),
    .value     (in_ch.sample_value),
    .idle      (core_idle),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res       (core_res),
    .res_take  (res_take)
  );

  // output register: refill when empty or being drained
  assign res_take = res_valid && (!out_vld_r || out_ch.ready);

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (res_take) out_vld_nxt = 1'b1;
    else if (out_ch.ready) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else out_vld_r <= out_vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (res_take) out_r <= core_res;
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.component      = out_r.component;
  assign out_ch.grad_amplitude = out_r.grad_amplitude;
  assign out_ch.grad_center    = out_r.grad_center;
  assign out_ch.grad_spread    = out_r.grad_spread;
  assign out_ch.residual       = out_r.residual;
  assign out_ch.zero_width     = out_r.zero_width;
  assign out_ch.last           = out_r.last;

  ap_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    core_idle |-> !res_valid)
    else $error("engine offers a result while idle");

  ap_eval_starts: assert property (@(posedge clk) disable iff (!rst_n)
    core_start |=> !core_idle)
    else $error("evaluate item accepted but engine stayed idle");

  ap_residual_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.last) |-> (out_ch.residual == '0))
    else $error("residual set on a result that is not last");

  ap_zero_width: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.zero_width) |->
      (out_ch.grad_amplitude == 32'sd0 && out_ch.grad_center == 32'sd0 &&
       out_ch.grad_spread == 32'sd0))
    else $error("zero width component carries nonzero gradients");

endmodule
